// ===== hdl/c5s2_pkg.sv =====
// shared constants, codes and control types for the 5x5 stride-2 convolution core
package c5s2_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_OUT    = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int KSIZE      = 5;
  localparam int NTAPS      = KSIZE * KSIZE;
  localparam int TAP_W      = $clog2(NTAPS);
  localparam int K_W        = $clog2(KSIZE);
  localparam int SLOT_W     = $clog2(KSIZE);
  localparam int LS_DEPTH   = KSIZE * MAX_WIDTH;
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int SUM_W      = 36;
  localparam int OCOORD_W   = 9;
  localparam int OPOS_W     = 11;
  localparam int DIM_W      = 11;
  localparam int ODIM_W     = 10;
  localparam int PAD_W      = 3;
  localparam int PAD_MAX    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PADDING = 3'd6;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic load_coef;
    logic load_pix;
    logic start;
    logic tap;
    logic next_out;
  } c5s2_cmd_t;

  typedef struct packed {
    logic empty;
    logic tap_last;
    logic busy;
    logic final_out;
  } c5s2_status_t;

endpackage

// ===== hdl/c5s2_ram.sv =====
// generic single-write, single-read RAM with registered read data
module c5s2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/c5s2_ctrl.sv =====
// controller: sequences pixel requests through window taps and result hand-off
module c5s2_ctrl import c5s2_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         op,
  output logic         in_stall,
  input  logic         out_stall,
  output logic         out_valid,
  output c5s2_cmd_t    cmd,
  input  c5s2_status_t status
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_TAPS  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state, state_next;
  logic       accept;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign accept    = in_valid && (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load_coef = accept && (op == OP_COEF);
    cmd.load_pix  = accept && (op == OP_PIXEL);
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_PIXEL)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status.empty) begin
          state_next = ST_IDLE;
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_TAPS;
        end
      end
      ST_TAPS: begin
        cmd.tap = 1'b1;
        if (status.tap_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (status.final_out) begin
            state_next = ST_IDLE;
          end else begin
            cmd.next_out = 1'b1;
            state_next   = ST_TAPS;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/c5s2_dp.sv =====
// datapath: registers, line store, coefficient store, window addressing and mac pipeline
module c5s2_dp import c5s2_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [4:0]              coef_index,
  input  logic signed [COEF_W-1:0] coef_value,
  input  logic signed [PIX_W-1:0] pixel,
  input  c5s2_cmd_t               cmd,
  output c5s2_status_t            status,
  output logic [OCOORD_W-1:0]     out_col,
  output logic [OCOORD_W-1:0]     out_row,
  output logic signed [SUM_W-1:0] conv_sum,
  output logic                    last
);

  localparam int ADDR_W = $clog2(LS_DEPTH);

  typedef struct packed {
    logic              ok;
    logic [OPOS_W-1:0] lo;
    logic [OPOS_W-1:0] hi;
  } range_t;

  // configuration registers
  logic [DIM_W-1:0]  frame_width, frame_height;
  logic [ODIM_W-1:0] out_width, out_height;
  logic [PAD_W-1:0]  pad_top, pad_left;
  logic              zero_padding;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [ODIM_W-1:0] ow_eff, oh_eff;
  logic [PAD_W-1:0]  pt_eff, pl_eff;

  always_comb begin
    w_eff  = (frame_width == '0) ? DIM_W'(1) :
             (frame_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width;
    h_eff  = (frame_height == '0) ? DIM_W'(1) :
             (frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height;
    ow_eff = (out_width == '0) ? ODIM_W'(1) :
             (out_width > ODIM_W'(MAX_OUT)) ? ODIM_W'(MAX_OUT) : out_width;
    oh_eff = (out_height == '0) ? ODIM_W'(1) :
             (out_height > ODIM_W'(MAX_OUT)) ? ODIM_W'(MAX_OUT) : out_height;
    pt_eff = (pad_top > PAD_W'(PAD_MAX)) ? PAD_W'(PAD_MAX) : pad_top;
    pl_eff = (pad_left > PAD_W'(PAD_MAX)) ? PAD_W'(PAD_MAX) : pad_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(64);
      frame_height <= DIM_W'(64);
      out_width    <= ODIM_W'(32);
      out_height   <= ODIM_W'(32);
      pad_top      <= PAD_W'(1);
      pad_left     <= PAD_W'(1);
      zero_padding <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_OUT_WIDTH:    out_width    <= cfg_data[ODIM_W-1:0];
        REG_OUT_HEIGHT:   out_height   <= cfg_data[ODIM_W-1:0];
        REG_PAD_TOP:      pad_top      <= cfg_data[PAD_W-1:0];
        REG_PAD_LEFT:     pad_left     <= cfg_data[PAD_W-1:0];
        REG_ZERO_PADDING: zero_padding <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // which outputs complete at source position pos along one axis
  function automatic range_t find_range(input logic [ROW_W-1:0] pos,
                                        input logic [PAD_W-1:0] pad,
                                        input logic [DIM_W-1:0] n_eff,
                                        input logic [ODIM_W-1:0] on_eff);
    range_t            r;
    logic signed [13:0] t;
    logic signed [13:0] tu;
    logic [OPOS_W-1:0] cap;
    t   = $signed({4'b0, pos}) + $signed({11'b0, pad}) - 14'sd4;
    cap = {1'b0, on_eff} - OPOS_W'(1);
    if ({1'b0, pos} == (n_eff - DIM_W'(1))) begin
      // last line: every window that reaches past the edge finishes here
      tu   = (t + 14'sd1) >>> 1;
      r.lo = (t < 0) ? '0 : OPOS_W'(tu);
      tu   = (t + 14'sd4) >>> 1;
      r.hi = OPOS_W'(tu);
      r.ok = 1'b1;
    end else begin
      tu   = t >>> 1;
      r.lo = OPOS_W'(tu);
      r.hi = r.lo;
      r.ok = (t >= 0) && !t[0];
    end
    if (r.hi > cap) begin
      r.hi = cap;
    end
    r.ok = r.ok && (r.lo <= r.hi);
    return r;
  endfunction

  // source position
  logic [COL_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos, cur_y;
  logic [SLOT_W-1:0] row_slot, cur_slot;
  range_t            rng_x, rng_y, rx_next, ry_next;

  always_comb begin
    rx_next = find_range(ROW_W'(col_pos), pl_eff, w_eff, ow_eff);
    ry_next = find_range(row_pos, pt_eff, h_eff, oh_eff);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_pos  <= '0;
      row_pos  <= '0;
      row_slot <= '0;
    end else if (cmd.load_pix) begin
      if (({1'b0, col_pos} + DIM_W'(1)) >= w_eff) begin
        col_pos <= '0;
        if (({1'b0, row_pos} + DIM_W'(1)) >= h_eff) begin
          row_pos  <= '0;
          row_slot <= '0;
        end else begin
          row_pos  <= row_pos + ROW_W'(1);
          row_slot <= (row_slot == SLOT_W'(KSIZE - 1)) ? '0 : row_slot + SLOT_W'(1);
        end
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      cur_y    <= row_pos;
      cur_slot <= row_slot;
      rng_x    <= rx_next;
      rng_y    <= ry_next;
    end
  end

  // coefficient store
  logic signed [COEF_W-1:0] coef [NTAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NTAPS; i++) begin
        coef[i] <= '0;
      end
    end else if (cmd.load_coef && (coef_index < TAP_W'(NTAPS))) begin
      coef[coef_index] <= coef_value;
    end
  end

  // output and tap iteration
  logic [OPOS_W-1:0] ox, oy;
  logic [K_W-1:0]    kj, ki;
  logic [TAP_W-1:0]  tidx;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ox <= rng_x.lo;
      oy <= rng_y.lo;
    end else if (cmd.next_out) begin
      if (ox == rng_x.hi) begin
        ox <= rng_x.lo;
        oy <= oy + OPOS_W'(1);
      end else begin
        ox <= ox + OPOS_W'(1);
      end
    end
    if (cmd.start || cmd.next_out) begin
      kj   <= '0;
      ki   <= '0;
      tidx <= '0;
    end else if (cmd.tap) begin
      tidx <= tidx + TAP_W'(1);
      if (ki == K_W'(KSIZE - 1)) begin
        ki <= '0;
        kj <= kj + K_W'(1);
      end else begin
        ki <= ki + K_W'(1);
      end
    end
  end

  // window addressing
  logic signed [13:0] sy, sx;
  logic               row_out, col_out, zero_tap;
  logic [ROW_W-1:0]   sy_c, dy;
  logic [COL_W-1:0]   sx_c;
  logic [SLOT_W-1:0]  d, slot;
  logic [ADDR_W-1:0]  raddr, waddr;

  always_comb begin
    sy = $signed({2'b0, oy, 1'b0}) - $signed({11'b0, pt_eff}) + $signed({11'b0, kj});
    sx = $signed({2'b0, ox, 1'b0}) - $signed({11'b0, pl_eff}) + $signed({11'b0, ki});
    row_out = (sy < 0) || (sy >= $signed({3'b0, h_eff}));
    col_out = (sx < 0) || (sx >= $signed({3'b0, w_eff}));
    if (sy < 0) begin
      sy_c = '0;
    end else if (sy >= $signed({3'b0, h_eff})) begin
      sy_c = ROW_W'(h_eff - DIM_W'(1));
    end else begin
      sy_c = sy[ROW_W-1:0];
    end
    if (sx < 0) begin
      sx_c = '0;
    end else if (sx >= $signed({3'b0, w_eff})) begin
      sx_c = COL_W'(w_eff - DIM_W'(1));
    end else begin
      sx_c = sx[COL_W-1:0];
    end
    // rows in the window are always among the last five written
    dy       = cur_y - sy_c;
    d        = dy[SLOT_W-1:0];
    slot     = (cur_slot >= d) ? (cur_slot - d) : (cur_slot + SLOT_W'(KSIZE) - d);
    zero_tap = zero_padding && (row_out || col_out);
    raddr    = ADDR_W'({slot, sx_c});
    waddr    = ADDR_W'({row_slot, col_pos});
  end

  logic [PIX_W-1:0] rdata;

  c5s2_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.load_pix),
    .waddr (waddr),
    .wdata (pixel),
    .raddr (raddr),
    .rdata (rdata)
  );

  // mac pipeline: read, multiply, accumulate
  logic                     va, vb, za, fa, fb;
  logic [TAP_W-1:0]         ca;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= cmd.tap;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    za   <= zero_tap;
    ca   <= tidx;
    fa   <= (tidx == '0);
    fb   <= fa;
    if (za) begin
      prod <= '0;
    end else begin
      prod <= $signed(rdata) * coef[ca];
    end
    if (vb) begin
      acc <= fb ? SUM_W'(prod) : acc + SUM_W'(prod);
    end
  end

  assign status.empty     = !(rng_x.ok && rng_y.ok);
  assign status.tap_last  = (tidx == TAP_W'(NTAPS - 1));
  assign status.busy      = va || vb;
  assign status.final_out = (ox == rng_x.hi) && (oy == rng_y.hi);

  assign out_col  = ox[OCOORD_W-1:0];
  assign out_row  = oy[OCOORD_W-1:0];
  assign conv_sum = acc;
  assign last     = status.final_out;

endmodule

// ===== hdl/conv5x5_stride2_padded_core.sv =====
// 5x5 stride-2 convolution core with zero or edge-replicate padding
// a coefficient request is taken without a stall; a pixel request with no result
// passes through a prepare state; each result is summed over 25 taps through the
// single line store read port; no request is taken until the last result is handed off
// reset (rst, synchronous) restores register defaults, clears the coefficients and position
// the line store is not cleared
module conv5x5_stride2_padded_core import c5s2_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic [4:0]              coef_index,
  input  logic signed [COEF_W-1:0] coef_value,
  input  logic signed [PIX_W-1:0] pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OCOORD_W-1:0]     out_col,
  output logic [OCOORD_W-1:0]     out_row,
  output logic signed [SUM_W-1:0] conv_sum,
  output logic                    last
);

  c5s2_cmd_t    cmd;
  c5s2_status_t status;

  c5s2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  c5s2_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .pixel      (pixel),
    .cmd        (cmd),
    .status     (status),
    .out_col    (out_col),
    .out_row    (out_row),
    .conv_sum   (conv_sum),
    .last       (last)
  );

endmodule

// ===== test/conv5x5_stride2_padded_core_tb.sv =====
// self-checking testbench for the 5x5 stride-2 padded convolution core
module conv5x5_stride2_padded_core_tb import c5s2_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [OCOORD_W-1:0]     col;
    logic [OCOORD_W-1:0]     row;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } conv_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    op = OP_COEF;
  logic [4:0]              coef_index = '0;
  logic signed [COEF_W-1:0] coef_value = '0;
  logic signed [PIX_W-1:0] pixel = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [OCOORD_W-1:0]     out_col;
  logic [OCOORD_W-1:0]     out_row;
  logic signed [SUM_W-1:0] conv_sum;
  logic                    last;

  conv5x5_stride2_padded_core dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [CFG_DATA_W-1:0]   cfg_regs [7];
  logic signed [COEF_W-1:0] kernel [NTAPS];
  logic signed [PIX_W-1:0] rows_kept [LS_DEPTH];
  int                      pos_col, pos_row;
  conv_result_t            pending_sums [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // source coordinate that completes output o, or -1 if never produced
  function automatic int completes_at(input int o, input int pad, input int n);
    int s0, e;
    s0 = 2 * o - pad;
    e = s0 + 4;
    if (s0 > n - 1) return -1;
    if (e > n - 1) e = n - 1;
    if (e < 0) e = 0;
    return e;
  endfunction

  function automatic longint window_total(input int ox, input int oy, input int w,
                                          input int h, input int pt, input int pl,
                                          input bit zp);
    longint acc;
    int sy, sx;
    acc = 0;
    for (int kj = 0; kj < KSIZE; kj++) begin
      sy = 2 * oy - pt + kj;
      if (sy < 0 || sy >= h) begin
        if (zp) continue;
        sy = sy < 0 ? 0 : h - 1;
      end
      for (int ki = 0; ki < KSIZE; ki++) begin
        sx = 2 * ox - pl + ki;
        if (sx < 0 || sx >= w) begin
          if (zp) continue;
          sx = sx < 0 ? 0 : w - 1;
        end
        acc += longint'(rows_kept[(sy % KSIZE) * MAX_WIDTH + sx]) *
               longint'(kernel[kj * KSIZE + ki]);
      end
    end
    return acc;
  endfunction

  task automatic predict_request(input logic op_i, input logic [4:0] idx,
                                 input logic signed [15:0] cv,
                                 input logic signed [15:0] px);
    int w, h, ow, oh, pt, pl, n;
    bit zp;
    conv_result_t r;
    if (op_i == OP_COEF) begin
      if (idx < NTAPS) kernel[idx] = cv;
      return;
    end
    w  = clamp_int(cfg_regs[REG_FRAME_WIDTH], 1, MAX_WIDTH);
    h  = clamp_int(cfg_regs[REG_FRAME_HEIGHT], 1, MAX_HEIGHT);
    ow = clamp_int(cfg_regs[REG_OUT_WIDTH], 1, MAX_OUT);
    oh = clamp_int(cfg_regs[REG_OUT_HEIGHT], 1, MAX_OUT);
    pt = clamp_int(cfg_regs[REG_PAD_TOP], 0, PAD_MAX);
    pl = clamp_int(cfg_regs[REG_PAD_LEFT], 0, PAD_MAX);
    zp = cfg_regs[REG_ZERO_PADDING][0];
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    rows_kept[(pos_row % KSIZE) * MAX_WIDTH + pos_col] = px;
    n = 0;
    for (int oy = 0; oy < oh; oy++) begin
      if (completes_at(oy, pt, h) != pos_row) continue;
      for (int ox = 0; ox < ow; ox++) begin
        if (completes_at(ox, pl, w) != pos_col || n >= 9) continue;
        r.col = ox[OCOORD_W-1:0];
        r.row = oy[OCOORD_W-1:0];
        r.sum = window_total(ox, oy, w, h, pt, pl, zp);
        r.last = 1'b0;
        pending_sums.push_back(r);
        n++;
      end
    end
    if (n > 0) pending_sums[$].last = 1'b1;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // one request, sometimes with a random idle gap before it
  task automatic send_request(input logic op_i, input logic [4:0] idx,
                              input logic signed [15:0] cv, input logic signed [15:0] px);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= op_i;
    coef_index <= idx;
    coef_value <= cv;
    pixel      <= px;
    do @(posedge clk); while (in_stall);
    predict_request(op_i, idx, cv, px);
  endtask

  task automatic send_coef(input logic [4:0] idx, input logic signed [15:0] cv);
    send_request(OP_COEF, idx, cv, 16'($urandom));
  endtask

  task automatic send_pixel(input logic signed [15:0] px);
    send_request(OP_PIXEL, 5'($urandom), 16'($urandom), px);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int w, input int h, input int ow, input int oh,
                            input int pt, input int pl, input int zp);
    logic [CFG_DATA_W-1:0] vals [7];
    vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(ow), CFG_DATA_W'(oh),
             CFG_DATA_W'(pt), CFG_DATA_W'(pl), CFG_DATA_W'(zp)};
    wait_drained();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      case (i)
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_regs[i] = vals[i];
        REG_OUT_WIDTH, REG_OUT_HEIGHT:     cfg_regs[i] = vals[i] & 11'h3ff;
        REG_PAD_TOP, REG_PAD_LEFT:         cfg_regs[i] = vals[i] & 11'h7;
        default:                           cfg_regs[i] = vals[i] & 11'h1;
      endcase
      pos_col = 0;
      pos_row = 0;
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) out_stall <= $urandom_range(99) < stall_pct;

  always @(posedge clk) begin
    conv_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result col %0d row %0d", out_col, out_row));
      end else begin
        e = pending_sums.pop_front();
        if (out_col !== e.col)
          report_mismatch($sformatf("out_col %0d, expected %0d", out_col, e.col));
        if (out_row !== e.row)
          report_mismatch($sformatf("out_row %0d, expected %0d", out_row, e.row));
        if (conv_sum !== e.sum)
          report_mismatch($sformatf("conv_sum %0d, expected %0d (col %0d row %0d)",
                                    conv_sum, e.sum, e.col, e.row));
        if (last !== e.last)
          report_mismatch($sformatf("last %b, expected %b", last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    logic signed [15:0] edge_pix [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    set_config(4, 4, 2, 2, 1, 1, 1);
    send_coef(5'd0, 16'sh8000);
    send_coef(5'd24, 16'sh7fff);
    send_coef(5'd12, 16'sh4000);
    send_coef(5'd31, 16'sh1234);   // index past the kernel is dropped
    for (int i = 0; i < 16; i++) send_pixel(edge_pix[i % 4]);
  endtask

  task automatic test_config_extremes();
    set_config(1, 1, 1, 1, 0, 0, 0);
    repeat (2) send_pixel(16'sh8000);
    set_config(0, 0, 0, 0, 7, 7, 1);
    repeat (2) send_pixel(16'sh7fff);
    set_config(2047, 2, 1023, 1023, 4, 4, 0);
    repeat (4) send_pixel(16'($urandom));
    set_config(1024, 1, 512, 512, 4, 4, 1);
    repeat (3) send_pixel(16'($urandom));
    set_config(5, 3, 3, 2, 2, 3, 0);
    repeat (15) send_pixel(16'($urandom));
  endtask

  // well-formed frames with random content, some coefficient noise and cut frames
  task automatic test_random_phase(input int idle, input int stall, input int n_items);
    int w, h, count, frame_len;
    send_idle_pct = 0;
    stall_pct = 0;
    w = $urandom_range(10, 1);
    h = $urandom_range(8, 1);
    set_config(w, h, $urandom_range(9, 0), $urandom_range(9, 0), $urandom_range(7, 0),
               $urandom_range(7, 0), $urandom_range(1, 0));
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < 8; i++) send_coef(5'($urandom_range(24, 0)), 16'($urandom));
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(99) < 10) begin
        send_coef(5'($urandom), 16'($urandom));
      end else begin
        frame_len = w * h;
        if ($urandom_range(3) == 0) frame_len = $urandom_range(frame_len, 1);
        if (frame_len > n_items - count) frame_len = n_items - count;
        for (int p = 0; p < frame_len; p++) send_pixel(16'($urandom));
        count += frame_len;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 7; i++) cfg_regs[i] = '0;
    cfg_regs[REG_FRAME_WIDTH]  = 64;
    cfg_regs[REG_FRAME_HEIGHT] = 64;
    cfg_regs[REG_OUT_WIDTH]    = 32;
    cfg_regs[REG_OUT_HEIGHT]   = 32;
    cfg_regs[REG_PAD_TOP]      = 1;
    cfg_regs[REG_PAD_LEFT]     = 1;
    cfg_regs[REG_ZERO_PADDING] = 1;
    for (int i = 0; i < NTAPS; i++) kernel[i] = '0;
    pos_col = 0;
    pos_row = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_phase(0, 0, 10);
    test_random_phase(74, 0, 10);
    test_random_phase(0, 74, 10);
    test_random_phase(35, 35, 10);
    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
